// File: rtl/gregorian_date_difference_defines.svh
// ----------------------------------------------------------------------------
// Gregorian date difference: assertion macros
// Shared property wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gdd checker: same-cycle property failed");

// next-cycle implication, disabled while reset is asserted
`define GDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gdd checker: next-cycle property failed");

`endif

// File: rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Widths, constants, stage types and the month table for the date difference.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 14;
  localparam int MAX_YEAR   = 9999;

  localparam int IN_TDATA_W  = 48;   // 46 payload bits, zero filled to 6 bytes
  localparam int DIFF_W      = 23;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;

  // serial day of year 16383 fits in 23 unsigned bits
  localparam int SERIAL_W = 23;
  localparam int MSTART_W = 9;
  localparam int MDAY_W   = 10;

  // x / 25 == (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 43690
  localparam int MUL_W       = 16;
  localparam int DIV25_MUL   = 41944;
  localparam int DIV25_SHIFT = 20;
  localparam int PROD_W      = YEAR_W + MUL_W;
  localparam int QUOT_W      = 10;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;     // saturated year
    logic [YEAR_W-1:0]   prev;     // full years before the date
    logic [PROD_W-1:0]   prod_c;   // (prev/4)  * reciprocal of 25
    logic [PROD_W-1:0]   prod_q;   // (prev/16) * reciprocal of 25
    logic [PROD_W-1:0]   prod_y;   // year      * reciprocal of 25
    logic [MSTART_W-1:0] mstart;
    logic                late;     // month after February
    logic [DAY_W-1:0]    day;
  } gdd_s1_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] base;     // 365*prev + prev/4
    logic [QUOT_W-1:0]   corr;     // prev/100 - prev/400
    logic [MDAY_W-1:0]   mday;     // days in year up to and including the date
  } gdd_s2_t;

  function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MSTART_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/gregorian_date_difference.sv
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Signed day count from a first to a second proleptic Gregorian date.
// ----------------------------------------------------------------------------
// Takes one date pair per transaction and returns one result per transaction,
// in order. With out_tready held high a new pair is taken every cycle. The
// pipeline is three compute stages plus the output register: reciprocal
// multiplies for the divisions by 25, then the year/leap sums, then the
// serial day, then the subtraction with saturation. Idle stages close up
// under backpressure, so in_tready drops only when all four stages hold data
// and the output is stalled. Days are not checked against month length; a
// month outside 1..12 in either date sets out_tuser and forces the difference
// to zero. Years above the configured maximum are clamped to it.
module gregorian_date_difference (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, low bit up: first_day[4:0], first_month[3:0], first_year[13:0],
  // second_day[4:0], second_month[3:0], second_year[13:0], 2 zero bits
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gdd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata, low bit up: day_difference[22:0] (signed), 1 zero bit
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gdd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: bad_month[0]
  output logic [gdd_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  // lane 0 is the first date, lane 1 the second
  logic [gdd_pkg::DAY_W-1:0]   day_in   [2];
  logic [gdd_pkg::MONTH_W-1:0] month_in [2];
  logic [gdd_pkg::YEAR_W-1:0]  year_in  [2];

  gdd_pkg::gdd_s1_t s1_nxt [2];
  gdd_pkg::gdd_s1_t s1_r   [2];
  gdd_pkg::gdd_s2_t s2_nxt [2];
  gdd_pkg::gdd_s2_t s2_r   [2];
  logic [gdd_pkg::SERIAL_W-1:0] s3_nxt [2];
  logic [gdd_pkg::SERIAL_W-1:0] s3_r   [2];

  logic bad_nxt, bad1_r, bad2_r, bad3_r;
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv_out;

  logic signed [gdd_pkg::DIFF_W:0]   diff_full;
  logic        [gdd_pkg::DIFF_W-1:0] diff_nxt;
  logic        [gdd_pkg::DIFF_W-1:0] diff_r;
  logic                              bad_out_r;

  assign day_in[0]   = in_tdata[4:0];
  assign month_in[0] = in_tdata[8:5];
  assign year_in[0]  = in_tdata[22:9];
  assign day_in[1]   = in_tdata[27:23];
  assign month_in[1] = in_tdata[31:28];
  assign year_in[1]  = in_tdata[45:32];

  // flow control: a stage moves when it is empty or the next one moves
  assign adv_out   = !out_valid_r || out_tready;
  assign adv3      = !v3_r || adv_out;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  // stage 1: clamp, full years, reciprocal products, month table, month check
  always_comb begin
    logic [gdd_pkg::YEAR_W-1:0] ys;
    logic [gdd_pkg::YEAR_W-1:0] p;
    logic ok0, ok1;
    for (int i = 0; i < 2; i++) begin
      ys = (int'(year_in[i]) > gdd_pkg::MAX_YEAR) ?
           gdd_pkg::YEAR_W'(gdd_pkg::MAX_YEAR) : year_in[i];
      p  = (ys != '0) ? ys - gdd_pkg::YEAR_W'(1) : '0;
      s1_nxt[i].year   = ys;
      s1_nxt[i].prev   = p;
      s1_nxt[i].prod_c = gdd_pkg::PROD_W'(p >> 2) *
                         gdd_pkg::PROD_W'(gdd_pkg::DIV25_MUL);
      s1_nxt[i].prod_q = gdd_pkg::PROD_W'(p >> 4) *
                         gdd_pkg::PROD_W'(gdd_pkg::DIV25_MUL);
      s1_nxt[i].prod_y = gdd_pkg::PROD_W'(ys) *
                         gdd_pkg::PROD_W'(gdd_pkg::DIV25_MUL);
      s1_nxt[i].mstart = gdd_pkg::month_start(month_in[i]);
      s1_nxt[i].late   = month_in[i] > gdd_pkg::MONTH_FEB;
      s1_nxt[i].day    = day_in[i];
    end
    ok0 = (month_in[0] >= gdd_pkg::MONTH_FIRST) && (month_in[0] <= gdd_pkg::MONTH_LAST);
    ok1 = (month_in[1] >= gdd_pkg::MONTH_FIRST) && (month_in[1] <= gdd_pkg::MONTH_LAST);
    bad_nxt = !ok0 || !ok1;
  end

  // stage 2: quotients, leap test, year base and day of year
  always_comb begin
    logic [gdd_pkg::QUOT_W-1:0] q100, q400, qy;
    logic [gdd_pkg::YEAR_W:0]   qy25;
    logic                       div25, leap;
    for (int i = 0; i < 2; i++) begin
      q100  = s1_r[i].prod_c[gdd_pkg::DIV25_SHIFT +: gdd_pkg::QUOT_W];
      q400  = s1_r[i].prod_q[gdd_pkg::DIV25_SHIFT +: gdd_pkg::QUOT_W];
      qy    = s1_r[i].prod_y[gdd_pkg::DIV25_SHIFT +: gdd_pkg::QUOT_W];
      qy25  = (gdd_pkg::YEAR_W+1)'(qy) * (gdd_pkg::YEAR_W+1)'(25);
      div25 = qy25 == {1'b0, s1_r[i].year};
      // with the year divisible by 4: by 100 iff by 25, by 400 iff also by 16
      leap  = (s1_r[i].year[1:0] == 2'b00) &&
              (!div25 || (s1_r[i].year[3:0] == 4'b0000));
      s2_nxt[i].base = gdd_pkg::SERIAL_W'(s1_r[i].prev) * gdd_pkg::SERIAL_W'(365) +
                       gdd_pkg::SERIAL_W'(s1_r[i].prev >> 2);
      s2_nxt[i].corr = q100 - q400;
      s2_nxt[i].mday = gdd_pkg::MDAY_W'(s1_r[i].mstart) +
                       gdd_pkg::MDAY_W'(s1_r[i].day) +
                       gdd_pkg::MDAY_W'(leap && s1_r[i].late);
    end
  end

  // stage 3: serial day number
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s3_nxt[i] = s2_r[i].base - gdd_pkg::SERIAL_W'(s2_r[i].corr) +
                  gdd_pkg::SERIAL_W'(s2_r[i].mday);
    end
  end

  // stage 4: difference, saturation, bad-month override
  always_comb begin
    diff_full = $signed({1'b0, s3_r[1]}) - $signed({1'b0, s3_r[0]});
    if (bad3_r) begin
      diff_nxt = '0;
    end else if (diff_full[gdd_pkg::DIFF_W] != diff_full[gdd_pkg::DIFF_W-1]) begin
      diff_nxt = diff_full[gdd_pkg::DIFF_W] ? {1'b1, {(gdd_pkg::DIFF_W-1){1'b0}}}
                                            : {1'b0, {(gdd_pkg::DIFF_W-1){1'b1}}};
    end else begin
      diff_nxt = diff_full[gdd_pkg::DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r   <= s1_nxt;
      bad1_r <= bad_nxt;
    end
    if (adv2) begin
      s2_r   <= s2_nxt;
      bad2_r <= bad1_r;
    end
    if (adv3) begin
      s3_r   <= s3_nxt;
      bad3_r <= bad2_r;
    end
    if (adv_out) begin
      diff_r    <= diff_nxt;
      bad_out_r <= bad3_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, diff_r};
  assign out_tuser  = bad_out_r;

endmodule

// File: rtl/gdd_checker.sv
// ----------------------------------------------------------------------------
// gdd_checker
// Port-level properties of the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_date_difference_defines.svh"

module gdd_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gdd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [gdd_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  // a bad month always reports a zero difference
  `GDD_ASSERT_NOW(a_bad_month_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)

  // the input side stalls only when the pipe is full and the output is held
  `GDD_ASSERT_NOW(a_ready_only_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready)

  // a held result stays put
  `GDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind gregorian_date_difference gdd_port_checker u_gdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
